// ----- design/rlt_pkg.sv -----
// package for the router link table block
// holds sizes, command and status codes and the sequencer state type; no dependencies
package rlt_pkg;

   localparam int MAX_ROUTERS_DEF = 16;
   localparam int MAX_LINKS_DEF   = 10;

   localparam int ID_W = 32;

   typedef enum logic [2:0] {
      CMD_LOAD   = 3'd0,
      CMD_FLAG   = 3'd1,
      CMD_LINK   = 3'd2,
      CMD_DELETE = 3'd3,
      CMD_ROUTE  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2,
      ST_DUP      = 2'd3
   } status_type;

   localparam logic [7:0] SEL_WHOLE = 8'd4;
   localparam logic [7:0] FLAG_BASE = 8'd15;
   localparam logic [7:0] FLAG_STEP = 8'd16;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_FIND   = 13'b0000000000010,  // scan id memory for the node id / other_id
      S_FINDW  = 13'b0000000000100,
      S_EXEC   = 13'b0000000001000,  // act on the found entries
      S_DLINK  = 13'b0000000010000,  // compact link lists of every entry
      S_DLINKW = 13'b0000000100000,
      S_DSHIFT = 13'b0000001000000,  // move later entries down one place
      S_DSHW   = 13'b0000010000000,
      S_BPOP   = 13'b0000100000000,  // search: take next queued router
      S_BLINK  = 13'b0001000000000,  // search: read next link
      S_BLOOK  = 13'b0010000000000,  // search: look the target up
      S_BLOOKW = 13'b0100000000000,
      S_RESP   = 13'b1000000000000
   } state_type;

endpackage

// ----- design/rlt_ram.sv -----
// generic single-port write, single-port read ram with registered read
// no dependencies
module rlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- design/router_link_table_with_reachability_top.sv -----
// top level of the router link table: command sequencer over the entry memories
// depends on rlt_pkg and rlt_ram
// every command first scans the id memory, one id read per stored router through one read port;
// load, set flag, add link and unused codes then answer; delete also compacts every link list
// and moves each later entry down one place; route check also pops queued routers and looks
// up the target of each link walked
// one item at a time: busy is high from accept through the rsp_ strobe.
// reset clears the router count and control state; memories are not cleared.
module router_link_table_with_reachability_top #(
   parameter int MAX_ROUTERS = rlt_pkg::MAX_ROUTERS_DEF,
   parameter int MAX_LINKS   = rlt_pkg::MAX_LINKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_node_id,
   input  logic [31:0] req_other_id,
   input  logic [7:0]  req_flag_select,
   input  logic [7:0]  req_flag_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_route_exists,
   output logic [7:0]  rsp_flag_out
);

   localparam int RW = $clog2(MAX_ROUTERS);
   localparam int CW = $clog2(MAX_ROUTERS + 1);
   localparam int KW = $clog2(MAX_LINKS + 1);
   localparam int TDEPTH = MAX_ROUTERS * MAX_LINKS;
   localparam int TW = $clog2(TDEPTH);

   rlt_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;

   // latched command
   logic [2:0]  cmd_ff, cmd_in;
   logic [31:0] id_ff, id_in, oth_ff, oth_in;
   logic [7:0]  sel_ff, sel_in, val_ff, val_in;

   // lookup results
   logic          hit_ff, hit_in, ohit_ff, ohit_in;
   logic [RW-1:0] idx_ff, idx_in;
   logic [CW-1:0] scan_ff, scan_in;     // entry scan pointer
   logic [KW-1:0] k_ff, k_in;           // link read pointer
   logic [KW-1:0] w_ff, w_in;           // link write pointer
   logic [KW-1:0] lc_ff, lc_in;         // current link count
   logic [31:0]   tgt_ff, tgt_in;       // link target under test

   // search
   logic [MAX_ROUTERS-1:0] vis_ff, vis_in;
   logic [CW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [RW-1:0] cur_ff, cur_in;
   logic          route_ff, route_in;
   logic          fetch_ff, fetch_in;   // queue read in flight
   logic          lcok_ff, lcok_in;     // link count of cur latched

   // result
   logic          rv_ff, rv_in;
   logic [1:0]    rs_ff, rs_in;
   logic [7:0]    rf_ff, rf_in;

   // memory ports
   logic          id_we, fl_we, lc_we, lt_we, q_we;
   logic [RW-1:0] id_wa, fl_wa, lc_wa, q_wa, id_ra, fl_ra, lc_ra, q_ra;
   logic [31:0]   id_wd, id_rd;
   logic [7:0]    fl_wd, fl_rd;
   logic [KW-1:0] lc_wd, lc_rd;
   logic [TW-1:0] lt_wa, lt_ra;
   logic [31:0]   lt_wd, lt_rd;
   logic [RW-1:0] q_wd, q_rd;

   rlt_ram #(.WIDTH(32), .DEPTH(MAX_ROUTERS)) u_id (
      .clock, .wr_en(id_we), .wr_addr(id_wa), .wr_data(id_wd), .rd_addr(id_ra),
      .rd_data(id_rd));
   rlt_ram #(.WIDTH(8), .DEPTH(MAX_ROUTERS)) u_flag (
      .clock, .wr_en(fl_we), .wr_addr(fl_wa), .wr_data(fl_wd), .rd_addr(fl_ra),
      .rd_data(fl_rd));
   rlt_ram #(.WIDTH(KW), .DEPTH(MAX_ROUTERS)) u_lcnt (
      .clock, .wr_en(lc_we), .wr_addr(lc_wa), .wr_data(lc_wd), .rd_addr(lc_ra),
      .rd_data(lc_rd));
   rlt_ram #(.WIDTH(32), .DEPTH(TDEPTH)) u_link (
      .clock, .wr_en(lt_we), .wr_addr(lt_wa), .wr_data(lt_wd), .rd_addr(lt_ra),
      .rd_data(lt_rd));
   rlt_ram #(.WIDTH(RW), .DEPTH(MAX_ROUTERS)) u_queue (
      .clock, .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd), .rd_addr(q_ra),
      .rd_data(q_rd));

   // link slot address of entry r, link j
   function automatic logic [TW-1:0] slot(input logic [RW-1:0] r, input logic [KW-1:0] j);
      logic [TW+KW:0] a;
      a = (TW+KW+1)'(r) * (TW+KW+1)'(MAX_LINKS) + (TW+KW+1)'(j);
      return a[TW-1:0];
   endfunction

   logic [RW-1:0] scan_idx;
   logic [KW-1:0] k_lim;
   logic [KW-1:0] lc_lim;
   assign scan_idx = scan_ff[RW-1:0];
   assign k_lim    = (lc_ff < KW'(MAX_LINKS)) ? lc_ff : KW'(MAX_LINKS);
   assign lc_lim   = (lc_rd < KW'(MAX_LINKS)) ? lc_rd : KW'(MAX_LINKS);

   always_comb begin
      state_in = state_ff;  count_in = count_ff;
      cmd_in = cmd_ff;  id_in = id_ff;  oth_in = oth_ff;  sel_in = sel_ff;  val_in = val_ff;
      hit_in = hit_ff;  ohit_in = ohit_ff;  idx_in = idx_ff;  scan_in = scan_ff;
      k_in = k_ff;  w_in = w_ff;  lc_in = lc_ff;  tgt_in = tgt_ff;
      vis_in = vis_ff;  head_in = head_ff;  tail_in = tail_ff;  cur_in = cur_ff;
      route_in = route_ff;  fetch_in = fetch_ff;  lcok_in = lcok_ff;
      rv_in = 1'b0;  rs_in = rs_ff;  rf_in = rf_ff;
      id_we = 1'b0;  fl_we = 1'b0;  lc_we = 1'b0;  lt_we = 1'b0;  q_we = 1'b0;
      id_wa = '0;  fl_wa = '0;  lc_wa = '0;  q_wa = '0;  lt_wa = '0;
      id_wd = '0;  fl_wd = '0;  lc_wd = '0;  q_wd = '0;  lt_wd = '0;
      id_ra = scan_idx;  fl_ra = idx_ff;  lc_ra = idx_ff;  q_ra = head_ff[RW-1:0];
      lt_ra = slot(cur_ff, k_ff);

      unique case (state_ff)
         rlt_pkg::S_IDLE: begin
            if (start && !rv_ff) begin
               cmd_in = req_command;  id_in = req_node_id;  oth_in = req_other_id;
               sel_in = req_flag_select;  val_in = req_flag_value;
               hit_in = 1'b0;  ohit_in = 1'b0;  scan_in = '0;  route_in = 1'b0;
               state_in = rlt_pkg::S_FIND;
            end
         end
         // issue an id read per entry, compare it in the following wait state
         rlt_pkg::S_FIND: begin
            if (scan_ff >= count_ff) begin
               idx_in = hit_ff ? idx_ff : cur_ff;
               state_in = rlt_pkg::S_EXEC;
            end else state_in = rlt_pkg::S_FINDW;
         end
         rlt_pkg::S_FINDW: begin
            if (!hit_ff && id_rd == id_ff) begin hit_in = 1'b1; idx_in = scan_idx; end
            if (!ohit_ff && id_rd == oth_ff) begin ohit_in = 1'b1; cur_in = scan_idx; end
            scan_in = scan_ff + 1'b1;
            state_in = rlt_pkg::S_FIND;
         end
         // flag and link count of idx are now on the read ports
         rlt_pkg::S_EXEC: begin
            rs_in = rlt_pkg::ST_DONE;
            rf_in = hit_ff ? fl_rd : 8'd0;
            state_in = rlt_pkg::S_RESP;
            case (cmd_ff)
               rlt_pkg::CMD_LOAD: begin
                  if (hit_ff) rs_in = rlt_pkg::ST_DUP;
                  else if (count_ff >= CW'(MAX_ROUTERS)) rs_in = rlt_pkg::ST_FULL;
                  else begin
                     id_we = 1'b1;  id_wa = count_ff[RW-1:0];  id_wd = id_ff;
                     fl_we = 1'b1;  fl_wa = count_ff[RW-1:0];  fl_wd = val_ff;
                     lc_we = 1'b1;  lc_wa = count_ff[RW-1:0];  lc_wd = '0;
                     count_in = count_ff + 1'b1;
                     rf_in = val_ff;
                  end
               end
               rlt_pkg::CMD_FLAG: begin
                  if (!hit_ff) rs_in = rlt_pkg::ST_NOTFOUND;
                  else begin
                     fl_wd = fl_rd;
                     if (sel_ff <= 8'd2) begin
                        if (val_ff == 8'd0) fl_wd = fl_rd & ~(8'd1 << sel_ff[1:0]);
                        else if (val_ff == 8'd1) fl_wd = fl_rd | (8'd1 << sel_ff[1:0]);
                     end else if (sel_ff == rlt_pkg::SEL_WHOLE && val_ff <= 8'd15) begin
                        fl_wd = rlt_pkg::FLAG_BASE + (val_ff << 4);
                     end
                     fl_we = 1'b1;  fl_wa = idx_ff;  rf_in = fl_wd;
                  end
               end
               rlt_pkg::CMD_LINK: begin
                  if (!hit_ff || !ohit_ff) rs_in = rlt_pkg::ST_NOTFOUND;
                  else if (lc_rd >= KW'(MAX_LINKS)) rs_in = rlt_pkg::ST_FULL;
                  else begin
                     lt_we = 1'b1;  lt_wa = slot(idx_ff, lc_rd);  lt_wd = oth_ff;
                     lc_we = 1'b1;  lc_wa = idx_ff;  lc_wd = lc_rd + 1'b1;
                     fl_we = 1'b1;  fl_wa = idx_ff;  fl_wd = fl_rd + rlt_pkg::FLAG_STEP;
                     rf_in = fl_wd;
                  end
               end
               rlt_pkg::CMD_DELETE: begin
                  rf_in = 8'd0;
                  if (!hit_ff) rs_in = rlt_pkg::ST_NOTFOUND;
                  else begin
                     cur_in = '0;  k_in = '0;  w_in = '0;  lc_in = '0;
                     lc_ra = '0;
                     state_in = rlt_pkg::S_DLINKW;
                  end
               end
               rlt_pkg::CMD_ROUTE: begin
                  if (!hit_ff) rs_in = rlt_pkg::ST_NOTFOUND;
                  else begin
                     vis_in = '0;  vis_in[idx_ff] = 1'b1;
                     q_we = 1'b1;  q_wa = '0;  q_wd = idx_ff;
                     head_in = '0;  tail_in = CW'(1);
                     state_in = rlt_pkg::S_BPOP;
                  end
               end
               default: ;
            endcase
         end
         // delete: lc_rd holds link count of cur; start compaction
         rlt_pkg::S_DLINKW: begin
            lc_in = lc_rd;  k_in = '0;  w_in = '0;
            lt_ra = slot(cur_ff, '0);
            state_in = rlt_pkg::S_DLINK;
         end
         // delete: lt_rd holds link k of cur
         rlt_pkg::S_DLINK: begin
            if (k_ff >= k_lim) begin
               lc_we = 1'b1;  lc_wa = cur_ff;  lc_wd = w_ff;
               if (CW'(cur_ff) + 1'b1 >= count_ff) begin
                  scan_in = CW'(idx_ff);
                  id_ra = idx_ff + 1'b1;  fl_ra = idx_ff + 1'b1;  lc_ra = idx_ff + 1'b1;
                  k_in = '0;
                  state_in = rlt_pkg::S_DSHW;
               end else begin
                  cur_in = cur_ff + 1'b1;
                  lc_ra = cur_ff + 1'b1;
                  state_in = rlt_pkg::S_DLINKW;
               end
            end else begin
               if (lt_rd != id_ff) begin
                  lt_we = 1'b1;  lt_wa = slot(cur_ff, w_ff);  lt_wd = lt_rd;
                  w_in = w_ff + 1'b1;
               end
               k_in = k_ff + 1'b1;
               lt_ra = slot(cur_ff, k_ff + 1'b1);
            end
         end
         // shift: wait state issues reads of entry scan+1
         rlt_pkg::S_DSHW: begin
            if (scan_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = rlt_pkg::S_RESP;
            end else begin
               id_ra = scan_idx + 1'b1;  fl_ra = scan_idx + 1'b1;  lc_ra = scan_idx + 1'b1;
               k_in = '0;
               lt_ra = slot(scan_idx + 1'b1, '0);
               state_in = rlt_pkg::S_DSHIFT;
            end
         end
         // shift: copy one entry header with its first link slot, then the other slots one a cycle
         rlt_pkg::S_DSHIFT: begin
            if (k_ff == '0) begin
               id_we = 1'b1;  id_wa = scan_idx;  id_wd = id_rd;
               fl_we = 1'b1;  fl_wa = scan_idx;  fl_wd = fl_rd;
               lc_we = 1'b1;  lc_wa = scan_idx;  lc_wd = lc_rd;
            end
            lt_we = 1'b1;  lt_wa = slot(scan_idx, k_ff);  lt_wd = lt_rd;
            if (k_ff == KW'(MAX_LINKS - 1)) begin
               scan_in = scan_ff + 1'b1;
               state_in = rlt_pkg::S_DSHW;
            end else begin
               k_in = k_ff + 1'b1;
               lt_ra = slot(scan_idx + 1'b1, k_ff + 1'b1);
            end
         end
         // search: pop the queue
         rlt_pkg::S_BPOP: begin
            if (head_ff >= tail_ff) state_in = rlt_pkg::S_RESP;
            else begin
               q_ra = head_ff[RW-1:0];
               head_in = head_ff + 1'b1;
               k_in = '0;
               fetch_in = 1'b1;
               state_in = rlt_pkg::S_BLINK;
            end
         end
         rlt_pkg::S_BLINK: begin
            if (fetch_ff) begin
               // queue data arrived, fetch link count and first link
               cur_in = q_rd;  lc_ra = q_rd;  lt_ra = slot(q_rd, '0);
               k_in = '0;
               fetch_in = 1'b0;
               lcok_in = 1'b0;
            end else begin
               if (!lcok_ff) begin
                  lc_in = lc_rd;
                  lcok_in = 1'b1;
               end
               if (k_ff >= (lcok_ff ? k_lim : lc_lim))
                  state_in = rlt_pkg::S_BPOP;
               else if (lt_rd == oth_ff) begin
                  route_in = 1'b1;  state_in = rlt_pkg::S_RESP;
               end else begin
                  tgt_in = lt_rd;  scan_in = '0;
                  id_ra = '0;
                  state_in = rlt_pkg::S_BLOOK;
               end
            end
         end
         // search: find the target's index
         rlt_pkg::S_BLOOK: begin
            if (scan_ff >= count_ff) begin
               k_in = k_ff + 1'b1;
               lt_ra = slot(cur_ff, k_ff + 1'b1);
               state_in = rlt_pkg::S_BLINK;
            end else state_in = rlt_pkg::S_BLOOKW;
         end
         rlt_pkg::S_BLOOKW: begin
            if (id_rd == tgt_ff) begin
               if (!vis_ff[scan_idx] && tail_ff < CW'(MAX_ROUTERS)) begin
                  vis_in[scan_idx] = 1'b1;
                  q_we = 1'b1;  q_wa = tail_ff[RW-1:0];  q_wd = scan_idx;
                  tail_in = tail_ff + 1'b1;
               end
               scan_in = count_ff;
            end else scan_in = scan_ff + 1'b1;
            state_in = rlt_pkg::S_BLOOK;
         end
         rlt_pkg::S_RESP: begin
            rv_in = 1'b1;
            state_in = rlt_pkg::S_IDLE;
         end
         default: state_in = rlt_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rlt_pkg::S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
      cmd_ff <= cmd_in;  id_ff <= id_in;  oth_ff <= oth_in;  sel_ff <= sel_in;
      val_ff <= val_in;  hit_ff <= hit_in;  ohit_ff <= ohit_in;  idx_ff <= idx_in;
      scan_ff <= scan_in;  k_ff <= k_in;  w_ff <= w_in;  lc_ff <= lc_in;
      tgt_ff <= tgt_in;  vis_ff <= vis_in;
      cur_ff <= cur_in;  route_ff <= route_in;  rs_ff <= rs_in;  rf_ff <= rf_in;
      fetch_ff <= fetch_in;  lcok_ff <= lcok_in;
   end

   assign busy             = (state_ff != rlt_pkg::S_IDLE) || rv_ff;
   assign rsp_valid        = rv_ff;
   assign rsp_status       = rs_ff;
   assign rsp_route_exists = route_ff;
   assign rsp_flag_out     = rf_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ROUTERS)) else $error("router count out of range");
   a_busy_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result strobe while not busy");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe repeated");
   a_queue: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff || state_ff == rlt_pkg::S_IDLE) else $error("queue underrun");
`endif

endmodule

// ----- tb/tb_router_link_table_with_reachability_top.sv -----
// testbench for router_link_table_with_reachability_top: directed, random and graph tests
// keeps its own copy of the router table and predicts every result; depends on rlt_pkg
`timescale 1ns / 1ps

module tb_router_link_table_with_reachability_top;

   localparam int NR = rlt_pkg::MAX_ROUTERS_DEF;
   localparam int NL = rlt_pkg::MAX_LINKS_DEF;
   localparam int CYCLE_LIMIT = 30_000_000;
   localparam int POOL_N = 24;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_command;
   logic [31:0] req_node_id;
   logic [31:0] req_other_id;
   logic [7:0]  req_flag_select;
   logic [7:0]  req_flag_value;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_route_exists;
   logic [7:0]  rsp_flag_out;

   typedef struct packed {
      logic [1:0] status;
      logic       route;
      logic [7:0] flag;
   } answer_type;

   // table copy kept by the testbench
   logic [31:0] tbl_id [NR];
   logic [7:0]  tbl_flag [NR];
   int          tbl_links [NR];
   logic [31:0] tbl_target [NR][NL];
   int          tbl_count;

   answer_type  pending_answers[$];
   logic [31:0] id_pool [POOL_N];
   int          error_count;
   int          items_sent;
   int          answers_seen;
   int          routes_found;
   int          burst_left;
   longint      cycle_count = 0;

   router_link_table_with_reachability_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_node_id(req_node_id),
      .req_other_id(req_other_id), .req_flag_select(req_flag_select),
      .req_flag_value(req_flag_value), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_route_exists(rsp_route_exists),
      .rsp_flag_out(rsp_flag_out)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int find_router(logic [31:0] id);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_id[i] == id) return i;
      return -1;
   endfunction

   // breadth-first search over the stored links
   function automatic logic search_route(int src, logic [31:0] dest);
      logic seen [NR];
      int   fifo [NR];
      int   head;
      int   tail;
      int   r;
      int   ti;
      head = 0;
      tail = 0;
      for (int i = 0; i < NR; i++) seen[i] = 1'b0;
      seen[src] = 1'b1;
      fifo[tail] = src;
      tail = tail + 1;
      while (head < tail) begin
         r = fifo[head];
         head = head + 1;
         for (int k = 0; k < tbl_links[r]; k++) begin
            if (tbl_target[r][k] == dest) return 1'b1;
            ti = find_router(tbl_target[r][k]);
            if (ti >= 0 && !seen[ti] && tail < NR) begin
               seen[ti] = 1'b1;
               fifo[tail] = ti;
               tail = tail + 1;
            end
         end
      end
      return 1'b0;
   endfunction

   // apply one command to the table copy and return its answer
   function automatic answer_type apply_command(logic [2:0] cmd, logic [31:0] id,
                                                logic [31:0] other, logic [7:0] sel,
                                                logic [7:0] val);
      answer_type a;
      int      idx;
      int      ti;
      int      w;
      logic [7:0] f;
      a = '0;
      a.status = rlt_pkg::ST_DONE;
      idx = find_router(id);
      case (cmd)
         rlt_pkg::CMD_LOAD: begin
            if (idx >= 0) a.status = rlt_pkg::ST_DUP;
            else if (tbl_count >= NR) a.status = rlt_pkg::ST_FULL;
            else begin
               tbl_id[tbl_count] = id;
               tbl_flag[tbl_count] = val;
               tbl_links[tbl_count] = 0;
               idx = tbl_count;
               tbl_count++;
            end
         end
         rlt_pkg::CMD_FLAG: begin
            if (idx < 0) a.status = rlt_pkg::ST_NOTFOUND;
            else begin
               f = tbl_flag[idx];
               if (sel <= 2) begin
                  if (val == 0) f[sel] = 1'b0;
                  else if (val == 1) f[sel] = 1'b1;
               end else if (sel == rlt_pkg::SEL_WHOLE && val <= 15) begin
                  f = rlt_pkg::FLAG_BASE + rlt_pkg::FLAG_STEP * val;
               end
               tbl_flag[idx] = f;
            end
         end
         rlt_pkg::CMD_LINK: begin
            ti = find_router(other);
            if (idx < 0 || ti < 0) a.status = rlt_pkg::ST_NOTFOUND;
            else if (tbl_links[idx] >= NL) a.status = rlt_pkg::ST_FULL;
            else begin
               tbl_target[idx][tbl_links[idx]] = other;
               tbl_links[idx]++;
               tbl_flag[idx] = tbl_flag[idx] + rlt_pkg::FLAG_STEP;
            end
         end
         rlt_pkg::CMD_DELETE: begin
            if (idx < 0) a.status = rlt_pkg::ST_NOTFOUND;
            else begin
               // drop every link to the id, then close the gap
               for (int i = 0; i < tbl_count; i++) begin
                  w = 0;
                  for (int j = 0; j < tbl_links[i]; j++)
                     if (tbl_target[i][j] != id) begin
                        tbl_target[i][w] = tbl_target[i][j];
                        w = w + 1;
                     end
                  tbl_links[i] = w;
               end
               for (int i = idx; i + 1 < tbl_count; i++) begin
                  tbl_id[i] = tbl_id[i+1];
                  tbl_flag[i] = tbl_flag[i+1];
                  tbl_links[i] = tbl_links[i+1];
                  for (int j = 0; j < NL; j++) tbl_target[i][j] = tbl_target[i+1][j];
               end
               tbl_count--;
               idx = -1;
            end
         end
         rlt_pkg::CMD_ROUTE: begin
            if (idx < 0) a.status = rlt_pkg::ST_NOTFOUND;
            else a.route = search_route(idx, other);
         end
         default: ;
      endcase
      a.flag = (idx >= 0) ? tbl_flag[idx] : 8'd0;
      return a;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      $display("mismatch on %s: got %0d, expected %0d (answer %0d)",
               what, got, want, answers_seen);
   endtask

   // result checker
   always @(negedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected answer", 1, 0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_route_exists !== want.route)
               report_mismatch("route_exists", rsp_route_exists, want.route);
            if (rsp_flag_out !== want.flag)
               report_mismatch("flag_out", rsp_flag_out, want.flag);
            if (want.route) routes_found++;
         end
         answers_seen++;
      end
   end

   // send one item; called at a rising edge, returns after the edge that accepts it, plus any random gap
   task automatic send_item(logic [2:0] cmd, logic [31:0] id, logic [31:0] other,
                            logic [7:0] sel, logic [7:0] val);
      int gap;
      req_command <= cmd;
      req_node_id <= id;
      req_other_id <= other;
      req_flag_select <= sel;
      req_flag_value <= val;
      start <= 1'b1;
      do @(negedge clock); while (busy);
      @(posedge clock);
      pending_answers.push_back(apply_command(cmd, id, other, sel, val));
      items_sent++;
      // bursts with random gaps in between
      if (burst_left > 0) burst_left--;
      else begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(0, 40);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // hold off until every answer is in
   task automatic drain_answers();
      start <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_id();
      if ($urandom_range(0, 19) == 0) return $urandom;
      return id_pool[$urandom_range(0, POOL_N - 1)];
   endfunction

   task automatic test_directed();
      send_item(rlt_pkg::CMD_FLAG, 32'd0, 32'd0, 8'd0, 8'd1);           // empty table
      send_item(rlt_pkg::CMD_LOAD, 32'd0, 32'd0, 8'd0, 8'h00);
      send_item(rlt_pkg::CMD_LOAD, 32'hFFFF_FFFF, 32'd0, 8'd0, 8'hFF);
      send_item(rlt_pkg::CMD_LOAD, 32'd0, 32'd0, 8'd0, 8'h55);          // duplicate id
      send_item(rlt_pkg::CMD_FLAG, 32'd0, 32'd0, 8'd0, 8'd1);
      send_item(rlt_pkg::CMD_FLAG, 32'd0, 32'd0, 8'd2, 8'd1);
      send_item(rlt_pkg::CMD_FLAG, 32'hFFFF_FFFF, 32'd0, 8'd1, 8'd0);
      send_item(rlt_pkg::CMD_FLAG, 32'd0, 32'd0, 8'd1, 8'd7);           // neither 0 nor 1
      send_item(rlt_pkg::CMD_FLAG, 32'd0, 32'd0, rlt_pkg::SEL_WHOLE, 8'd15);
      send_item(rlt_pkg::CMD_FLAG, 32'd0, 32'd0, rlt_pkg::SEL_WHOLE, 8'd16); // kept
      send_item(rlt_pkg::CMD_FLAG, 32'd0, 32'd0, 8'd3, 8'd0);           // select not used
      send_item(rlt_pkg::CMD_FLAG, 32'd0, 32'd0, 8'hFF, 8'hFF);
      send_item(rlt_pkg::CMD_LINK, 32'd0, 32'd5, 8'd0, 8'd0);           // target unknown
      send_item(rlt_pkg::CMD_LINK, 32'd0, 32'd0, 8'd0, 8'd0);           // self link
      send_item(rlt_pkg::CMD_LINK, 32'd0, 32'hFFFF_FFFF, 8'd0, 8'd0);
      send_item(rlt_pkg::CMD_LINK, 32'd0, 32'hFFFF_FFFF, 8'd0, 8'd0);   // duplicate link
      send_item(rlt_pkg::CMD_ROUTE, 32'd0, 32'hFFFF_FFFF, 8'd0, 8'd0);
      send_item(rlt_pkg::CMD_ROUTE, 32'hFFFF_FFFF, 32'd0, 8'd0, 8'd0);
      send_item(rlt_pkg::CMD_ROUTE, 32'd0, 32'd9, 8'd0, 8'd0);          // unknown destination
      send_item(rlt_pkg::CMD_ROUTE, 32'd9, 32'd0, 8'd0, 8'd0);          // unknown source
      send_item(rlt_pkg::CMD_DELETE, 32'd9, 32'd0, 8'd0, 8'd0);         // unknown id
      send_item(rlt_pkg::CMD_DELETE, 32'hFFFF_FFFF, 32'd0, 8'd0, 8'd0); // links to it are dropped
      send_item(rlt_pkg::CMD_ROUTE, 32'd0, 32'hFFFF_FFFF, 8'd0, 8'd0);
      send_item(3'd7, 32'd0, 32'd0, 8'd0, 8'd0);                        // unused code
      send_item(3'd5, $urandom, $urandom, 8'($urandom), 8'($urandom));
      // full link list and full table
      for (int i = 0; i < NL; i++) send_item(rlt_pkg::CMD_LINK, 32'd0, 32'd0, 8'd0, 8'd0);
      for (int i = 0; i < NR + 2; i++)
         send_item(rlt_pkg::CMD_LOAD, id_pool[i], 32'd0, 8'd0, 8'($urandom));
      drain_answers();
   endtask

   task automatic clear_table();
      while (tbl_count > 0) send_item(rlt_pkg::CMD_DELETE, tbl_id[0], 32'd0, 8'd0, 8'd0);
   endtask

   task automatic test_random_mix(int n);
      logic [2:0] cmd;
      logic [7:0] sel;
      logic [7:0] val;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3:      cmd = rlt_pkg::CMD_LOAD;
            4, 5, 6:         cmd = rlt_pkg::CMD_FLAG;
            7, 8, 9, 10, 11: cmd = rlt_pkg::CMD_LINK;
            12, 13:          cmd = rlt_pkg::CMD_DELETE;
            14, 15, 16, 17:  cmd = rlt_pkg::CMD_ROUTE;
            default:         cmd = 3'($urandom_range(0, 7));
         endcase
         sel = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
         case ($urandom_range(0, 2))
            0:       val = 8'($urandom_range(0, 1));
            1:       val = 8'($urandom_range(0, 16));
            default: val = 8'($urandom);
         endcase
         send_item(cmd, pick_id(), pick_id(), sel, val);
         if (i % 400 == 399) drain_answers();
      end
   endtask

   // full tables with dense link graphs, then many route checks and occasional deletes
   task automatic test_route_graphs(int rounds);
      int nl;
      for (int r = 0; r < rounds; r++) begin
         clear_table();
         for (int i = 0; i < NR; i++)
            send_item(rlt_pkg::CMD_LOAD, id_pool[(i + r) % POOL_N], 32'd0, 8'd0,
                      8'($urandom));
         nl = $urandom_range(4, 30);
         for (int i = 0; i < nl; i++)
            send_item(rlt_pkg::CMD_LINK, tbl_id[$urandom_range(0, tbl_count - 1)],
                      tbl_id[$urandom_range(0, tbl_count - 1)], 8'd0, 8'd0);
         for (int i = 0; i < 40 && tbl_count > 0; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_item(rlt_pkg::CMD_DELETE, tbl_id[$urandom_range(0, tbl_count - 1)],
                         32'd0, 8'd0, 8'd0);
            else
               send_item(rlt_pkg::CMD_ROUTE, tbl_id[$urandom_range(0, tbl_count - 1)],
                         pick_id(), 8'd0, 8'd0);
         end
      end
   endtask

   initial begin
      error_count = 0;
      items_sent = 0;
      answers_seen = 0;
      routes_found = 0;
      burst_left = 0;
      tbl_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_command = rlt_pkg::CMD_LOAD;
      req_node_id = '0;
      req_other_id = '0;
      req_flag_select = '0;
      req_flag_value = '0;
      id_pool[0] = 32'd0;
      id_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_N; i++) id_pool[i] = $urandom;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      clear_table();
      test_random_mix(950);
      test_route_graphs(9);

      drain_answers();
      repeat (200) @(posedge clock);
      $display("sent %0d items, checked %0d answers, %0d found routes",
               items_sent, answers_seen, routes_found);
      $display("covered load, flags, links, deletes, route searches and unused codes");
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d answers missing", error_count, pending_answers.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
